FILE: src/ir_pulse_distance_decoder_assert.svh
// assertion macros shared by the decoder's checker
// expects signals clk and arst_n in the scope of each use
`ifndef IR_PULSE_DISTANCE_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define IRPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define IRPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/irpd_pkg.sv
// shared types and constants of the ir pulse distance decoder
// no dependencies
package irpd_pkg;

	// default build parameters
	localparam int TICK_MICROS_DEF       = 50;
	localparam int MARK_EXCESS_DEF       = 20;
	localparam int TOLERANCE_PERCENT_DEF = 45;

	// field widths
	localparam int DUR_W   = 16;
	localparam int US_W    = 16;
	localparam int CNT_W   = 6;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 16;
	// corrected nominal, numerator and divisor widths of the window unit
	localparam int VAL_W   = 17;
	localparam int NUM_W   = 24;
	localparam int DIV_W   = 17;
	localparam int QDEPTH  = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_BIT_COUNT     = 3'd0;
	localparam logic [IDX_W-1:0] REG_MSB_FIRST     = 3'd1;
	localparam logic [IDX_W-1:0] REG_BIT_MARK_US   = 3'd2;
	localparam logic [IDX_W-1:0] REG_ONE_SPACE_US  = 3'd3;
	localparam logic [IDX_W-1:0] REG_ZERO_SPACE_US = 3'd4;

	// register reset values
	localparam logic [CNT_W-1:0] BIT_COUNT_RST     = 6'd32;
	localparam logic             MSB_FIRST_RST     = 1'b0;
	localparam logic [US_W-1:0]  BIT_MARK_US_RST   = 16'd560;
	localparam logic [US_W-1:0]  ONE_SPACE_US_RST  = 16'd1690;
	localparam logic [US_W-1:0]  ZERO_SPACE_US_RST = 16'd560;

	typedef struct packed {
		logic [DUR_W-1:0] lo;
		logic [DUR_W-1:0] hi;
	} irpd_win_t;

	typedef struct packed {
		irpd_win_t mark;
		irpd_win_t one;
		irpd_win_t zero;
	} irpd_bounds_t;

	// classified item handed from front to back
	typedef struct packed {
		logic start;
		logic mark_ok;
		logic one_ok;
		logic zero_ok;
	} irpd_cls_t;

endpackage

FILE: src/irpd_bounds.sv
// window bound unit: scales the nominals and divides by the tick constant
// registered constant scaling, then a reciprocal multiplication into the bound registers; uses irpd_pkg
module irpd_bounds #(
	parameter int TICK_MICROS       = irpd_pkg::TICK_MICROS_DEF,
	parameter int MARK_EXCESS       = irpd_pkg::MARK_EXCESS_DEF,
	parameter int TOLERANCE_PERCENT = irpd_pkg::TOLERANCE_PERCENT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic [irpd_pkg::US_W-1:0]   bit_mark_us,
	input  logic [irpd_pkg::US_W-1:0]   one_space_us,
	input  logic [irpd_pkg::US_W-1:0]   zero_space_us,
	output irpd_pkg::irpd_bounds_t      bounds,
	output logic                        busy
);
	import irpd_pkg::*;

	localparam int LANES   = 6;
	localparam int DIVISOR = TICK_MICROS * 100;
	// floor(n / DIVISOR) equals (n * RECIP) >> SHIFT for every n below 2**NUM_W
	localparam int SHIFT   = NUM_W + $clog2(DIVISOR);
	localparam int MUL_W   = NUM_W + 2;
	localparam int PROD_W  = (SHIFT + DUR_W > NUM_W + MUL_W) ? SHIFT + DUR_W : NUM_W + MUL_W;
	localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) / longint'(DIVISOR)) + 64'd1;
	localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_L);
	localparam logic [NUM_W-1:0] LO_MUL = NUM_W'(100 - TOLERANCE_PERCENT);
	localparam logic [NUM_W-1:0] HI_MUL = NUM_W'(100 + TOLERANCE_PERCENT);
	localparam logic [VAL_W-1:0] EXCESS = VAL_W'(MARK_EXCESS);

	logic              load_q;
	logic              calc_q;
	logic [NUM_W-1:0]  num_q [LANES];
	logic [PROD_W-1:0] prod [LANES];
	logic [VAL_W-1:0]  val [3];
	logic [DUR_W-1:0]  lo_q [3];
	logic [DUR_W-1:0]  hi_q [3];

	// corrected nominals: mark gets the excess added, spaces lose it with a floor at zero
	always_comb begin
		val[0] = VAL_W'(bit_mark_us) + EXCESS;
		val[1] = (VAL_W'(one_space_us) > EXCESS) ? VAL_W'(one_space_us) - EXCESS : '0;
		val[2] = (VAL_W'(zero_space_us) > EXCESS) ? VAL_W'(zero_space_us) - EXCESS : '0;
	end

	// division by the tick constant as a multiplication by its scaled reciprocal
	always_comb begin
		for (int l = 0; l < LANES; l++)
			prod[l] = PROD_W'(num_q[l]) * RECIP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b1;
			calc_q <= 1'b0;
		end else if (restart) begin
			load_q <= 1'b1;
			calc_q <= 1'b0;
		end else begin
			load_q <= 1'b0;
			calc_q <= load_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_q) begin
			for (int k = 0; k < 3; k++) begin
				num_q[2*k]   <= NUM_W'(val[k]) * LO_MUL;
				num_q[2*k+1] <= NUM_W'(val[k]) * HI_MUL;
			end
		end
		if (calc_q) begin
			for (int k = 0; k < 3; k++) begin
				lo_q[k] <= prod[2*k][SHIFT +: DUR_W];
				hi_q[k] <= prod[2*k+1][SHIFT +: DUR_W] + 1'b1;
			end
		end
	end

	assign busy = load_q || calc_q;

	assign bounds.mark.lo = lo_q[0];
	assign bounds.mark.hi = hi_q[0];
	assign bounds.one.lo  = lo_q[1];
	assign bounds.one.hi  = hi_q[1];
	assign bounds.zero.lo = lo_q[2];
	assign bounds.zero.hi = hi_q[2];

endmodule

FILE: src/irpd_front.sv
// front end: input handshake and classification of a duration against the windows
// uses irpd_pkg
module irpd_front (
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [irpd_pkg::DUR_W-1:0]   duration_ticks,
	input  logic                         frame_start,
	input  irpd_pkg::irpd_bounds_t       bounds,
	input  logic                         bounds_busy,
	input  logic                         q_full,
	output logic                         push,
	output irpd_pkg::irpd_cls_t          cls
);
	import irpd_pkg::*;

	function automatic logic in_win(input logic [DUR_W-1:0] d, input irpd_win_t w);
		in_win = (d >= w.lo) && (d <= w.hi);
	endfunction

	assign in_ready = !bounds_busy && !q_full;
	assign push     = in_valid && in_ready;

	assign cls.start   = frame_start;
	assign cls.mark_ok = in_win(duration_ticks, bounds.mark);
	assign cls.one_ok  = in_win(duration_ticks, bounds.one);
	assign cls.zero_ok = in_win(duration_ticks, bounds.zero);

endmodule

FILE: src/irpd_queue.sv
// short queue of classified items between front and back
// uses irpd_pkg
module irpd_queue #(
	parameter int DEPTH = irpd_pkg::QDEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  irpd_pkg::irpd_cls_t push_data,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output irpd_pkg::irpd_cls_t head
);
	import irpd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	irpd_cls_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_QW-1:0]  fill_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (fill_q == CNT_QW'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= wrap_inc(wr_q);
			if (pop)
				rd_q <= wrap_inc(rd_q);
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

FILE: src/irpd_back.sv
// back end: frame assembly from classified items and the result register
// uses irpd_pkg
module irpd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_not_empty,
	input  irpd_pkg::irpd_cls_t           q_head,
	output logic                          pop,
	input  logic [irpd_pkg::CNT_W-1:0]    bit_count,
	input  logic                          msb_first,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [irpd_pkg::WORD_W-1:0]   data_word,
	output logic                          ok
);
	import irpd_pkg::*;

	logic              active_q;
	logic              expect_q;
	logic [CNT_W-1:0]  bits_q;
	logic [WORD_W-1:0] word_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] data_q;
	logic              ok_q;

	logic              act;
	logic              es;
	logic [CNT_W-1:0]  bd;
	logic [WORD_W-1:0] sw;
	logic [CNT_W-1:0]  bd_nx;
	logic [WORD_W-1:0] sw_nx;
	logic [CNT_W-1:0]  need;
	logic              bit_v;
	logic              fail;
	logic              done;

	assign pop = q_not_empty && (!out_valid_q || out_ready);

	always_comb begin
		act   = q_head.start || active_q;
		es    = q_head.start ? 1'b0 : expect_q;
		bd    = q_head.start ? '0 : bits_q;
		sw    = q_head.start ? '0 : word_q;
		bit_v = q_head.one_ok;
		if (bit_count == '0)
			need = CNT_W'(1);
		else if (bit_count > CNT_W'(WORD_W))
			need = CNT_W'(WORD_W);
		else
			need = bit_count;
		bd_nx = bd + 1'b1;
		if (msb_first)
			sw_nx = {sw[WORD_W-2:0], bit_v};
		else
			sw_nx = sw | (WORD_W'(bit_v) << bd[4:0]);
		fail = act && (es ? !(q_head.one_ok || q_head.zero_ok) : !q_head.mark_ok);
		done = act && es && !fail && (bd_nx >= need);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			expect_q    <= 1'b0;
			bits_q      <= '0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			if (pop && act) begin
				if (fail) begin
					active_q    <= 1'b0;
					expect_q    <= 1'b0;
					out_valid_q <= 1'b1;
				end else if (!es) begin
					active_q <= 1'b1;
					expect_q <= 1'b1;
					bits_q   <= bd;
					word_q   <= sw;
				end else begin
					active_q <= !done;
					expect_q <= 1'b0;
					bits_q   <= bd_nx;
					word_q   <= sw_nx;
					if (done)
						out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (fail || done)) begin
			data_q <= fail ? '0 : sw_nx;
			ok_q   <= !fail;
		end
	end

	assign out_valid = out_valid_q;
	assign data_word = data_q;
	assign ok        = ok_q;

endmodule

FILE: src/ir_pulse_distance_decoder.sv
// top level of the ir pulse distance decoder
// depends on irpd_pkg, irpd_bounds, irpd_front, irpd_queue and irpd_back
//
// Decodes measured infrared durations, one per transfer, alternating mark and space and
// starting at an item flagged frame_start. Each mark must lie in the tolerance window of
// bit_mark_us plus the mark excess; each space is tried against the one window, then the
// zero window, and sets a bit into a 32-bit word (MSB first by shifting, or LSB first by
// position). After bit_count bits the word comes out with ok=1; a duration outside its
// windows gives one result with ok=0 and data_word zero, after which items are dropped
// until the next frame_start. Throughput is one duration per clock while the queue has
// room and the bounds are not being worked out: the front classifies a duration in the
// cycle it is transferred, a two-entry queue decouples it from the back, and the back
// pops it, updates the frame state and loads the output register once that register is
// free or being read. The duration that completes or breaks the frame passes the queue
// and then the output register before out_valid rises; up to two more inputs are taken
// while a result still waits for out_ready. The six window bounds are worked out (constant
// scaling, then a reciprocal multiplication for the division by the tick constant) after
// reset and after every configuration write; in_ready stays low while they are worked out.
// Configuration writes are always taken and must only be issued while the decoder is idle.
module ir_pulse_distance_decoder #(
	parameter int TICK_MICROS       = irpd_pkg::TICK_MICROS_DEF,
	parameter int MARK_EXCESS       = irpd_pkg::MARK_EXCESS_DEF,
	parameter int TOLERANCE_PERCENT = irpd_pkg::TOLERANCE_PERCENT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [irpd_pkg::IDX_W-1:0]    cfg_index,
	input  logic [irpd_pkg::CFG_W-1:0]    cfg_data,
	// duration input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [irpd_pkg::DUR_W-1:0]    duration_ticks,
	input  logic                          frame_start,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [irpd_pkg::WORD_W-1:0]   data_word,
	output logic                          ok
);
	import irpd_pkg::*;

	// configuration registers
	logic [CNT_W-1:0] bit_count_q;
	logic             msb_first_q;
	logic [US_W-1:0]  bit_mark_us_q;
	logic [US_W-1:0]  one_space_us_q;
	logic [US_W-1:0]  zero_space_us_q;

	logic             cfg_write;
	irpd_bounds_t     bounds;
	logic             bounds_busy;
	irpd_cls_t        cls;
	irpd_cls_t        q_head;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_not_empty;

	// writes are never back-pressured
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q     <= BIT_COUNT_RST;
			msb_first_q     <= MSB_FIRST_RST;
			bit_mark_us_q   <= BIT_MARK_US_RST;
			one_space_us_q  <= ONE_SPACE_US_RST;
			zero_space_us_q <= ZERO_SPACE_US_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BIT_COUNT:     bit_count_q     <= cfg_data[CNT_W-1:0];
				REG_MSB_FIRST:     msb_first_q     <= cfg_data[0];
				REG_BIT_MARK_US:   bit_mark_us_q   <= cfg_data[US_W-1:0];
				REG_ONE_SPACE_US:  one_space_us_q  <= cfg_data[US_W-1:0];
				REG_ZERO_SPACE_US: zero_space_us_q <= cfg_data[US_W-1:0];
				default: ;  // unused indexes are ignored
			endcase
		end
	end

	// window bounds, recomputed on every configuration transfer
	irpd_bounds #(
		.TICK_MICROS       (TICK_MICROS),
		.MARK_EXCESS       (MARK_EXCESS),
		.TOLERANCE_PERCENT (TOLERANCE_PERCENT)
	) u_bounds (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (cfg_write),
		.bit_mark_us   (bit_mark_us_q),
		.one_space_us  (one_space_us_q),
		.zero_space_us (zero_space_us_q),
		.bounds        (bounds),
		.busy          (bounds_busy)
	);

	// classification of each incoming duration
	irpd_front u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.duration_ticks (duration_ticks),
		.frame_start    (frame_start),
		.bounds         (bounds),
		.bounds_busy    (bounds_busy),
		.q_full         (q_full),
		.push           (push),
		.cls            (cls)
	);

	// decoupling queue
	irpd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// frame assembly and result register
	irpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.bit_count   (bit_count_q),
		.msb_first   (msb_first_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_word   (data_word),
		.ok          (ok)
	);

endmodule

FILE: src/irpd_checker.sv
// port-level checks of the ir pulse distance decoder, bound to the top level
// depends on irpd_pkg and ir_pulse_distance_decoder_assert.svh
`include "ir_pulse_distance_decoder_assert.svh"

module irpd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [irpd_pkg::WORD_W-1:0]   data_word,
	input logic                          ok
);
	// a stalled result keeps its payload
	`IRPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data_word) && $stable(ok), "result changed while stalled")

	// a failed frame carries an all-zero word
	`IRPD_ASSERT_NOW(a_fail_zero, out_valid && !ok, data_word == '0, "failed frame with nonzero word")

	// a configuration transfer blocks input while the windows are recomputed
	`IRPD_ASSERT_NEXT(a_cfg_block, cfg_valid && cfg_ready, !in_ready, "input taken during window update")

	// a result only leaves through a transfer
	`IRPD_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(out_ready), "result dropped without transfer")

endmodule

bind ir_pulse_distance_decoder irpd_checker u_irpd_checker (.*);

FILE: dv/ir_pulse_distance_decoder_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the ir pulse distance decoder: directed frames, then random
// traffic under several register settings, each result checked against an in-bench decoder
// depends on irpd_pkg and the ir_pulse_distance_decoder rtl
module ir_pulse_distance_decoder_test;
	import irpd_pkg::*;

	// no register sits behind this index, writes to it must change nothing
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	// margin after the last expected result, for items still passing the queue and the output register
	localparam int DRAIN_CYCLES = 8;
	// longest run of cycles with no transfer on any channel before the run is abandoned
	localparam int QUIET_LIMIT = 3000;
	// length of the forced receiver stall in the back-pressure test
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              ok;
	} frame_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [DUR_W-1:0]    duration_ticks = '0;
	logic                frame_start = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [WORD_W-1:0]   data_word;
	logic                ok;

	// register copy kept by the bench, updated at each write transfer
	logic [CNT_W-1:0]    cfg_bits = BIT_COUNT_RST;
	logic                cfg_msb = MSB_FIRST_RST;
	logic [US_W-1:0]     mark_us = BIT_MARK_US_RST;
	logic [US_W-1:0]     one_us = ONE_SPACE_US_RST;
	logic [US_W-1:0]     zero_us = ZERO_SPACE_US_RST;

	// frame state of the bench decoder
	logic                in_frame = 1'b0;
	logic                want_space = 1'b0;
	logic [CNT_W-1:0]    bits_taken = '0;
	logic [WORD_W-1:0]   word_acc = '0;

	// results still owed by the block, oldest first
	frame_result_t       pending_words[$];

	// idling controls, in percent of cycles
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	// forced stall request, raised by the test and counted out by the receiver
	int                  hold_asked = 0;
	int                  hold_seen = 0;
	int                  hold_left = 0;

	int                  durations_sent = 0;
	int                  durations_used = 0;
	int                  reg_writes = 0;
	int                  frames_good = 0;
	int                  frames_rejected = 0;
	int                  bad_results = 0;
	int                  quiet_cycles = 0;

	ir_pulse_distance_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.duration_ticks (duration_ticks),
		.frame_start    (frame_start),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_word      (data_word),
		.ok             (ok)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// bench decoder
	// ------------------------------------------------------------------

	// tolerance window in ticks for a corrected nominal in microseconds,
	// both bounds cut to 16 bits like the hardware
	function automatic irpd_win_t window_for(input longint unsigned us);
		irpd_win_t        w;
		longint unsigned  lo_full;
		longint unsigned  hi_full;
		lo_full = us * (100 - TOLERANCE_PERCENT_DEF) / (TICK_MICROS_DEF * 100);
		hi_full = us * (100 + TOLERANCE_PERCENT_DEF) / (TICK_MICROS_DEF * 100) + 1;
		w.lo = lo_full[DUR_W-1:0];
		w.hi = hi_full[DUR_W-1:0];
		return w;
	endfunction

	// marks are widened by the excess
	function automatic irpd_win_t mark_window();
		return window_for(longint'(mark_us) + MARK_EXCESS_DEF);
	endfunction

	// spaces are shortened by the excess, clamped at zero
	function automatic irpd_win_t space_window(input logic [US_W-1:0] nominal);
		longint unsigned v;
		v = (nominal > MARK_EXCESS_DEF) ? longint'(nominal) - MARK_EXCESS_DEF : 0;
		return window_for(v);
	endfunction

	function automatic logic in_window(input logic [DUR_W-1:0] dur, input irpd_win_t w);
		return (dur >= w.lo) && (dur <= w.hi);
	endfunction

	// bits per frame, zero counts as one and anything past the word width as the width
	function automatic int unsigned frame_length();
		if (cfg_bits == 0)
			return 1;
		if (cfg_bits > WORD_W)
			return WORD_W;
		return cfg_bits;
	endfunction

	function automatic void reject_frame();
		pending_words.push_back('{word: '0, ok: 1'b0});
		in_frame = 1'b0;
		want_space = 1'b0;
	endfunction

	// advances the bench decoder by one duration, queues any result it owes,
	// returns 0 when the duration is dropped outside a frame
	function automatic logic decode_duration(input logic [DUR_W-1:0] dur, input logic first);
		logic bit_val;
		if (first) begin
			in_frame = 1'b1;
			want_space = 1'b0;
			bits_taken = '0;
			word_acc = '0;
		end
		if (!in_frame)
			return 1'b0;
		if (!want_space) begin
			if (in_window(dur, mark_window()))
				want_space = 1'b1;
			else
				reject_frame();
			return 1'b1;
		end
		// the one window wins where the two overlap
		if (in_window(dur, space_window(one_us))) begin
			bit_val = 1'b1;
		end else if (in_window(dur, space_window(zero_us))) begin
			bit_val = 1'b0;
		end else begin
			reject_frame();
			return 1'b1;
		end
		if (cfg_msb)
			word_acc = {word_acc[WORD_W-2:0], bit_val};
		else if (bit_val)
			word_acc[bits_taken[4:0]] = 1'b1;
		bits_taken = bits_taken + 1'b1;
		want_space = 1'b0;
		if (bits_taken >= frame_length()) begin
			pending_words.push_back('{word: word_acc, ok: 1'b1});
			in_frame = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		case (idx)
			REG_BIT_COUNT:     cfg_bits = val[CNT_W-1:0];
			REG_MSB_FIRST:     cfg_msb = val[0];
			REG_BIT_MARK_US:   mark_us = val[US_W-1:0];
			REG_ONE_SPACE_US:  one_us = val[US_W-1:0];
			REG_ZERO_SPACE_US: zero_us = val[US_W-1:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// duration values
	// ------------------------------------------------------------------

	// edges of the window are favoured
	function automatic logic [DUR_W-1:0] pick_inside(input irpd_win_t w);
		case ($urandom_range(3))
			0:       return w.lo;
			1:       return w.hi;
			default: return DUR_W'($urandom_range(w.hi, w.lo));
		endcase
	endfunction

	// just below or just above the window, or anywhere further out
	function automatic logic [DUR_W-1:0] pick_outside(input irpd_win_t w);
		if (w.lo != 0 && (w.hi == '1 || $urandom_range(1) == 0)) begin
			if ($urandom_range(1) == 0)
				return DUR_W'(w.lo - 1);
			return DUR_W'($urandom_range(w.lo - 1, 0));
		end
		if ($urandom_range(1) == 0)
			return DUR_W'(w.hi + 1);
		return DUR_W'($urandom_range(16'hFFFF, w.hi + 1));
	endfunction

	// ------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------

	// one duration transfer, with a random lead-in gap while the sender idles
	task automatic send_duration(input logic [DUR_W-1:0] dur, input logic first);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		duration_ticks <= dur;
		frame_start <= first;
		do
			@(posedge clk);
		while (!in_ready);
		durations_sent++;
		if (decode_duration(dur, first))
			durations_used++;
	endtask

	// writes all five registers back to back, valid held high across the burst,
	// optionally followed by a write to the unused index
	task automatic load_settings(input logic [CFG_W-1:0] bit_count, input logic msb,
			input logic [US_W-1:0] mark, input logic [US_W-1:0] one_space,
			input logic [US_W-1:0] zero_space, input logic poke_unused);
		logic [IDX_W-1:0] idx_list[6];
		logic [CFG_W-1:0] val_list[6];
		int               writes;
		idx_list = '{REG_BIT_COUNT, REG_MSB_FIRST, REG_BIT_MARK_US, REG_ONE_SPACE_US,
			REG_ZERO_SPACE_US, REG_UNUSED};
		val_list = '{bit_count, CFG_W'(msb), mark, one_space, zero_space, 16'hFFFF};
		writes = poke_unused ? 6 : 5;
		cfg_valid <= 1'b1;
		for (int i = 0; i < writes; i++) begin
			cfg_index <= idx_list[i];
			cfg_data <= val_list[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			apply_reg(idx_list[i], val_list[i]);
			reg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	// stops offering, waits for every owed result, then lets in-flight
	// durations that owe nothing pass through
	task automatic drain_decoder();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one frame of well-formed marks and spaces with random bits, sometimes
	// spoilt by one out-of-window duration or cut short before its end
	task automatic send_frame(input int flaw_pct, input int cut_pct);
		irpd_win_t        mw;
		irpd_win_t        sw;
		int               total;
		int               flaw_at;
		int               stop_at;
		logic [DUR_W-1:0] dur;
		total = 2 * frame_length();
		flaw_at = ($urandom_range(99) < flaw_pct) ? $urandom_range(total - 1) : total;
		stop_at = ($urandom_range(99) < cut_pct) ? $urandom_range(total - 1, 1) : total;
		mw = mark_window();
		for (int k = 0; k < stop_at && k <= flaw_at; k++) begin
			if (k % 2 == 0) begin
				dur = (k == flaw_at) ? pick_outside(mw) : pick_inside(mw);
			end else begin
				sw = ($urandom_range(1) == 0) ? space_window(one_us) : space_window(zero_us);
				dur = (k == flaw_at) ? pick_outside(sw) : pick_inside(sw);
			end
			send_duration(dur, k == 0);
		end
	endtask

	// mostly frames, some raw noise over the full field range
	task automatic run_random_traffic(input int target);
		int goal;
		goal = durations_used + target;
		while (durations_used < goal) begin
			if ($urandom_range(99) < 12)
				send_duration(DUR_W'($urandom_range(16'hFFFF)), $urandom_range(3) == 0);
			else
				send_frame(20, 6);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset settings: dropped items, rejects of marks and spaces, restart mid-frame
	task automatic test_rejects_and_restart();
		irpd_win_t mw;
		irpd_win_t ow;
		irpd_win_t zw;
		mw = mark_window();
		ow = space_window(one_us);
		zw = space_window(zero_us);
		send_duration(16'h0000, 1'b0);           // outside a frame, dropped
		send_duration(16'hFFFF, 1'b0);
		send_duration(DUR_W'(mw.lo - 1), 1'b1);  // mark too short
		send_duration(mw.lo, 1'b0);              // dropped after the reject
		send_duration(mw.lo, 1'b1);
		send_duration(ow.hi, 1'b0);
		send_duration(mw.hi, 1'b1);              // new frame discards the partial one
		send_duration(zw.lo, 1'b0);
		send_duration(DUR_W'(mw.hi + 1), 1'b0);  // mark too long
		send_duration(mw.lo, 1'b1);
		send_duration(DUR_W'(ow.hi + 1), 1'b0);  // space above the one window
		send_duration(mw.hi, 1'b1);
		send_duration(16'hFFFF, 1'b0);
		drain_decoder();
	endtask

	// count of zero, short frames both ways, nominals clamped below the excess
	task automatic test_frame_lengths_and_clamp();
		irpd_win_t mw;
		irpd_win_t ow;
		// zero bits per frame behaves as one
		load_settings(16'd0, 1'b1, BIT_MARK_US_RST, ONE_SPACE_US_RST, ZERO_SPACE_US_RST, 1'b0);
		mw = mark_window();
		ow = space_window(one_us);
		send_duration(mw.lo, 1'b1);
		send_duration(ow.lo, 1'b0);
		drain_decoder();
		// zero nominal below the excess clamps to a window at the origin
		load_settings(16'd2, 1'b0, BIT_MARK_US_RST, ONE_SPACE_US_RST, 16'd10, 1'b1);
		send_duration(mw.hi, 1'b1);
		send_duration(16'd0, 1'b0);
		send_duration(mw.lo, 1'b0);
		send_duration(ow.lo, 1'b0);
		drain_decoder();
		// both nominals clamped, windows coincide and the one side wins
		load_settings(16'd2, 1'b1, BIT_MARK_US_RST, 16'd0, 16'd10, 1'b0);
		send_duration(mw.lo, 1'b1);
		send_duration(16'd1, 1'b0);
		send_duration(mw.hi, 1'b0);
		send_duration(16'd0, 1'b0);
		drain_decoder();
	endtask

	// usual remote timing, byte frames, lsb first
	task automatic test_reference_timing();
		load_settings(16'd8, 1'b0, BIT_MARK_US_RST, ONE_SPACE_US_RST, ZERO_SPACE_US_RST, 1'b0);
		run_random_traffic(300);
		drain_decoder();
	endtask

	// random nominals, random length with junk above the count field, msb first
	task automatic test_random_settings();
		load_settings(CFG_W'({10'($urandom_range(1023)), CNT_W'($urandom_range(32, 1))}),
			1'b1, US_W'($urandom_range(4000)), US_W'($urandom_range(4000)),
			US_W'($urandom_range(4000)), 1'b0);
		run_random_traffic(300);
		drain_decoder();
	endtask

	// top of most fields: count past the word width, widest mark and one nominals, zero nominal at zero
	task automatic test_extreme_settings();
		load_settings(16'd63, 1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
		run_random_traffic(300);
		drain_decoder();
	endtask

	// one-bit frames while the receiver stalls for a long stretch, so the
	// output register and queue fill and the input side has to wait
	task automatic test_output_backpressure();
		load_settings(16'd1, 1'b1, 16'd0, 16'hFFFF, 16'd0, 1'b0);
		hold_asked <= hold_asked + 1;
		for (int i = 0; i < 30; i++)
			send_frame(10, 0);
		drain_decoder();
	endtask

	// ------------------------------------------------------------------
	// receiver, checker and watchdog
	// ------------------------------------------------------------------

	// out_ready: random idling, or a counted stall when a test asks for one
	always @(posedge clk) begin
		if (hold_asked != hold_seen) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// every result transfer is matched against the oldest owed result
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (ok)
				frames_good++;
			else
				frames_rejected++;
			if (pending_words.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("mismatch: unexpected result data_word %h ok %b", data_word, ok);
			end else begin
				want = pending_words.pop_front();
				if (data_word !== want.word || ok !== want.ok) begin
					bad_results++;
					if (bad_results <= 10)
						$display("mismatch: data_word %h (expected %h), ok %b (expected %b)",
							data_word, want.word, ok, want.ok);
				end
			end
		end
	end

	// a run with no transfer on any channel for too long has hung
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results owed",
				quiet_cycles, pending_words.size());
			$display("FAIL ir_pulse_distance_decoder");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles lightly, receiver heavily
		send_idle_pct = 22;
		recv_idle_pct = 67;
		test_rejects_and_restart();
		test_frame_lengths_and_clamp();
		test_reference_timing();

		// the other way round
		send_idle_pct = 67;
		recv_idle_pct = 22;
		test_random_settings();

		// full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_extreme_settings();
		test_output_backpressure();

		$display("covered %0d durations (%0d inside frames) over %0d register writes",
			durations_sent, durations_used, reg_writes);
		$display("%0d frames decoded, %0d rejected, %0d mismatches",
			frames_good, frames_rejected, bad_results);
		if (bad_results == 0 && pending_words.size() == 0)
			$display("PASS ir_pulse_distance_decoder");
		else
			$display("FAIL ir_pulse_distance_decoder");
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/irpd_pkg.sv
src/irpd_bounds.sv
src/irpd_front.sv
src/irpd_queue.sv
src/irpd_back.sv
src/ir_pulse_distance_decoder.sv
src/irpd_checker.sv
dv/ir_pulse_distance_decoder_test.sv
